// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/rdq_pkg.sv =====
// ----------------------------------------------------------------------------
// rdq_pkg
// Types and constants shared by the restricted deque modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rdq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int ADDR_WIDTH     = 3;
  localparam int APB_WIDTH      = 32;

  localparam logic [ADDR_WIDTH-1:0] REG_MODE_ADDR = 3'd0;

  localparam logic MODE_INPUT_RESTR  = 1'b0;
  localparam logic MODE_OUTPUT_RESTR = 1'b1;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DENIED    = 2'd3
  } status_e;

  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rdq_if.sv =====
// ----------------------------------------------------------------------------
// rdq_if
// Request and response channels of the restricted deque.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdq_req_if #(
  parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  rdq_pkg::req_e                req_type;
  logic signed [DATA_WIDTH-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface rdq_rsp_if #(
  parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH      = rdq_pkg::DEPTH_DEF
);
  localparam int CNT_WIDTH = $clog2(DEPTH + 1);

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] pop_value;
  rdq_pkg::status_e             status;
  logic [CNT_WIDTH-1:0]         fill_level;

  modport source (output valid, output pop_value, output status, output fill_level,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input fill_level,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rdq_cell.sv =====
// ----------------------------------------------------------------------------
// rdq_cell
// One deque slot: shifts with its neighbors on front push and front pop,
// loads the pushed word when it is the slot just past the rear.
// ----------------------------------------------------------------------------
`default_nettype none

module rdq_cell #(
  parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF,
  parameter int CNT_WIDTH  = 5,
  parameter int IDX        = 0
) (
  input  wire logic                    clk_i,
  input  wire rdq_pkg::cell_ctrl_t     ctrl_i,
  input  wire logic [CNT_WIDTH-1:0]    count_i,
  input  wire logic [DATA_WIDTH-1:0]   push_value_i,
  input  wire logic [DATA_WIDTH-1:0]   left_data_i,
  input  wire logic [DATA_WIDTH-1:0]   right_data_i,
  output logic      [DATA_WIDTH-1:0]   data_o,
  output logic      [DATA_WIDTH-1:0]   rear_data_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  at_tail;
  logic                  is_rear;

  assign at_tail = (count_i == CNT_WIDTH'(IDX));
  assign is_rear = (count_i == CNT_WIDTH'(IDX + 1));

  always_comb begin
    data_d = data_q;
    if (ctrl_i.push_front) begin
      data_d = left_data_i;
    end else if (ctrl_i.pop_front) begin
      data_d = right_data_i;
    end else if (ctrl_i.push_rear && at_tail) begin
      data_d = push_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o      = data_q;
  assign rear_data_o = is_rear ? data_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/restricted_deque_top.sv =====
// ----------------------------------------------------------------------------
// restricted_deque_top
// Input- or output-restricted double-ended queue built as a row of cells.
// ----------------------------------------------------------------------------
// Requests arrive on req_i (valid/ready); each transfer carries an operation
// (push front, push rear, pop front, pop rear) and a word for pushes.
// Every request yields exactly one response transfer on rsp_o: the popped
// word (zero unless a pop succeeded), a status and the fill level after it.
// The APB register at address 0 selects the mode: input restricted (no front
// push) or output restricted (no rear pop). Write it only while idle.
// A response is presented in the cycle after its request transfer.
// Throughput: one request per cycle when not stalled; cell k holds the k-th
// entry from the front, so a front push or pop shifts the whole row at once
// and a rear access touches only the cell picked by the entry count.
// req_i.ready stays high while the response register is empty or being
// drained; a stalled receiver holds the response and blocks new requests.
// Reset empties the deque and selects input-restricted mode; cell contents
// are left unknown and are never shown before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module restricted_deque_top #(
  parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  rdq_req_if.sink                              req_i,
  rdq_rsp_if.source                            rsp_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rdq_pkg::ADDR_WIDTH-1:0]  paddr,
  input  wire logic [rdq_pkg::APB_WIDTH-1:0]   pwdata,
  output logic      [rdq_pkg::APB_WIDTH-1:0]   prdata,
  output logic                                 pready
);

  localparam int CNT_WIDTH = $clog2(DEPTH + 1);

  logic                  mode_q;
  logic [CNT_WIDTH-1:0]  count_q, count_d;
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] pop_value_q, pop_value_d;
  rdq_pkg::status_e      status_q, status_d;
  logic [CNT_WIDTH-1:0]  fill_q;

  logic                  accept;
  logic                  forbidden;
  logic                  is_push;
  logic                  go;
  rdq_pkg::cell_ctrl_t   ctrl;
  logic [DATA_WIDTH-1:0] rear_word;

  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic [DATA_WIDTH-1:0] rear_part  [DEPTH];
  logic [DATA_WIDTH-1:0] left_data  [DEPTH];
  logic [DATA_WIDTH-1:0] right_data [DEPTH];

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == rdq_pkg::REG_MODE_ADDR) ?
                  {{(rdq_pkg::APB_WIDTH-1){1'b0}}, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rdq_pkg::MODE_INPUT_RESTR;
    end else if (psel && penable && pwrite && (paddr == rdq_pkg::REG_MODE_ADDR)) begin
      mode_q <= pwdata[0];
    end
  end

  // request decode
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_push     = (req_i.req_type == rdq_pkg::REQ_PUSH_FRONT) ||
                       (req_i.req_type == rdq_pkg::REQ_PUSH_REAR);
  assign forbidden   = (mode_q == rdq_pkg::MODE_OUTPUT_RESTR) ?
                       (req_i.req_type == rdq_pkg::REQ_POP_REAR) :
                       (req_i.req_type == rdq_pkg::REQ_PUSH_FRONT);

  always_comb begin
    if (forbidden) begin
      status_d = rdq_pkg::ST_DENIED;
    end else if (is_push) begin
      status_d = (count_q == CNT_WIDTH'(DEPTH)) ? rdq_pkg::ST_OVERFLOW : rdq_pkg::ST_OK;
    end else begin
      status_d = (count_q == '0) ? rdq_pkg::ST_UNDERFLOW : rdq_pkg::ST_OK;
    end
  end

  assign go              = accept && (status_d == rdq_pkg::ST_OK);
  assign ctrl.push_front = go && (req_i.req_type == rdq_pkg::REQ_PUSH_FRONT);
  assign ctrl.push_rear  = go && (req_i.req_type == rdq_pkg::REQ_PUSH_REAR);
  assign ctrl.pop_front  = go && (req_i.req_type == rdq_pkg::REQ_POP_FRONT);

  always_comb begin
    count_d     = count_q;
    pop_value_d = '0;
    if (go) begin
      case (req_i.req_type) inside
        rdq_pkg::REQ_PUSH_FRONT, rdq_pkg::REQ_PUSH_REAR: begin
          count_d = count_q + CNT_WIDTH'(1);
        end
        rdq_pkg::REQ_POP_FRONT: begin
          count_d     = count_q - CNT_WIDTH'(1);
          pop_value_d = cell_data[0];
        end
        default: begin
          count_d     = count_q - CNT_WIDTH'(1);
          pop_value_d = rear_word;
        end
      endcase
    end
  end

  // row of cells
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign left_data[k] = req_i.push_value;
    end else begin : g_body
      assign left_data[k] = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_data[k] = '0;
    end else begin : g_inner
      assign right_data[k] = cell_data[k+1];
    end

    rdq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_WIDTH  (CNT_WIDTH),
      .IDX        (k)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .push_value_i (req_i.push_value),
      .left_data_i  (left_data[k]),
      .right_data_i (right_data[k]),
      .data_o       (cell_data[k]),
      .rear_data_o  (rear_part[k])
    );
  end

  always_comb begin
    rear_word = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rear_word = rear_word | rear_part[k];
    end
  end

  // state and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_value_q <= pop_value_d;
      status_q    <= status_d;
      fill_q      <= count_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.pop_value  = pop_value_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.fill_level = fill_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rdq_checker.sv =====
// ----------------------------------------------------------------------------
// rdq_checker
// Port-level checks on the restricted deque response channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rdq_checker #(
  parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF,
  parameter int CNT_WIDTH  = 5
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  rsp_valid_i,
  input wire logic                  rsp_ready_i,
  input wire logic [DATA_WIDTH-1:0] pop_value_i,
  input wire logic [1:0]            status_i,
  input wire logic [CNT_WIDTH-1:0]  fill_level_i
);

  logic denied_or_bad;

  assign denied_or_bad = (status_i != rdq_pkg::ST_OK);

  `ASSERT_IMP(a_fill_bound, clk_i, rst_ni, rsp_valid_i, fill_level_i <= CNT_WIDTH'(DEPTH))
  `ASSERT_IMP(a_fail_zero, clk_i, rst_ni, rsp_valid_i && denied_or_bad, pop_value_i == '0)
  `ASSERT_IMP(a_underflow_empty, clk_i, rst_ni, rsp_valid_i && (status_i == rdq_pkg::ST_UNDERFLOW), fill_level_i == '0)
  `ASSERT_IMP(a_overflow_full, clk_i, rst_ni, rsp_valid_i && (status_i == rdq_pkg::ST_OVERFLOW), fill_level_i == CNT_WIDTH'(DEPTH))
  `ASSERT_NXT(a_stall_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(pop_value_i) && $stable(status_i) && $stable(fill_level_i))

endmodule

bind restricted_deque_top rdq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH),
  .CNT_WIDTH  (CNT_WIDTH)
) u_rdq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .pop_value_i  (rsp_o.pop_value),
  .status_i     (rsp_o.status),
  .fill_level_i (rsp_o.fill_level)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the restricted deque.
// ----------------------------------------------------------------------------
// Requests go in through the request channel with random gaps, and responses
// come back through a randomly stalled response channel. A local copy of the
// ring, the front pointer, the entry count and the mode gives the response
// that each request transfer should produce. Each response transfer is
// checked field by field against the oldest pending prediction. Directed
// requests cover value extremes, every operation in both modes, denied
// operations, underflow, overflow and a mode change while entries are held.
// Mode-aware random fill and drain runs follow, which often wrap the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import rdq_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int DW             = DATA_WIDTH_DEF;
  localparam int TIMEOUT_CYCLES = 500_000;

  typedef struct packed {
    logic signed [DW-1:0] pop_value;
    status_e              status;
    logic [4:0]           fill_level;
  } deque_rsp_t;

  logic clk;
  logic rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [APB_WIDTH-1:0]  pwdata;
  logic [APB_WIDTH-1:0]  prdata;
  logic                  pready;

  rdq_req_if #(.DATA_WIDTH(DW)) req_if ();
  rdq_rsp_if #(.DATA_WIDTH(DW), .DEPTH(DEPTH)) rsp_if ();

  restricted_deque_top #(.DEPTH(DEPTH), .DATA_WIDTH(DW)) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic signed [DW-1:0] ring_q [DEPTH];
  logic [3:0]           front_q;
  logic [4:0]           count_q;
  logic                 mode_q;

  deque_rsp_t predicted_rsp_q[$];
  int                   mismatch_cnt;
  bit                   idling_on;
  int                   stall_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int gap_length();
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] exp_v,
                                        logic [31:0] act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, exp_v, act_v);
    end
  endfunction

  function automatic deque_rsp_t deque_apply(req_e op, logic signed [DW-1:0] word);
    deque_rsp_t rsp;
    logic       denied;
    logic [3:0] slot;
    rsp.pop_value = '0;
    rsp.status    = ST_OK;
    denied = (mode_q == MODE_INPUT_RESTR) ? (op == REQ_PUSH_FRONT) : (op == REQ_POP_REAR);
    if (denied) begin
      rsp.status = ST_DENIED;
    end else if (op == REQ_PUSH_FRONT || op == REQ_PUSH_REAR) begin
      if (count_q == DEPTH) begin
        rsp.status = ST_OVERFLOW;
      end else begin
        if (op == REQ_PUSH_FRONT) begin
          front_q = front_q - 4'd1;
          slot    = front_q;
        end else begin
          slot = front_q + count_q[3:0];
        end
        ring_q[slot] = word;
        count_q++;
      end
    end else begin
      if (count_q == 0) begin
        rsp.status = ST_UNDERFLOW;
      end else begin
        if (op == REQ_POP_FRONT) begin
          slot    = front_q;
          front_q = front_q + 4'd1;
        end else begin
          slot = front_q + count_q[3:0] - 4'd1;
        end
        rsp.pop_value = ring_q[slot];
        count_q--;
      end
    end
    rsp.fill_level = count_q;
    return rsp;
  endfunction

  // check the response first: it belongs to an earlier request
  always @(posedge clk) begin
    deque_rsp_t want;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (predicted_rsp_q.size() == 0) begin
          note_mismatch("unexpected response pop_value", '0, rsp_if.pop_value);
        end else begin
          want = predicted_rsp_q.pop_front();
          if (rsp_if.pop_value !== want.pop_value) begin
            note_mismatch("pop_value", want.pop_value, rsp_if.pop_value);
          end
          if (rsp_if.status !== want.status) begin
            note_mismatch("status", 32'(want.status), 32'(rsp_if.status));
          end
          if (rsp_if.fill_level !== want.fill_level) begin
            note_mismatch("fill_level", 32'(want.fill_level), 32'(rsp_if.fill_level));
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        predicted_rsp_q.push_back(deque_apply(req_if.req_type, req_if.push_value));
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_if.ready = 1'b0;
      stall_left--;
    end else if (idling_on && $urandom_range(0, 3) == 0) begin
      rsp_if.ready = 1'b0;
      stall_left   = gap_length() - 1;
    end else begin
      rsp_if.ready = 1'b1;
    end
  end

  task automatic send_req(req_e op, logic signed [DW-1:0] word);
    int gap;
    gap = (idling_on && $urandom_range(0, 2) == 0) ? gap_length() : 0;
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.req_type   = op;
    req_if.push_value = word;
    req_if.valid      = 1'b1;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req_if.valid = 1'b0;
    while (predicted_rsp_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic apb_access(logic wr, logic [ADDR_WIDTH-1:0] addr,
                            logic [APB_WIDTH-1:0] wdata, output logic [APB_WIDTH-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_mode(logic mode);
    logic [APB_WIDTH-1:0] rd;
    apb_access(1'b1, REG_MODE_ADDR, {{(APB_WIDTH-1){1'b0}}, mode}, rd);
    mode_q = mode;
    apb_access(1'b0, REG_MODE_ADDR, '0, rd);
    if (rd[0] !== mode) begin
      note_mismatch("restrict_mode readback", 32'(mode), 32'(rd[0]));
    end
  endtask

  task automatic test_input_restricted();
    send_req(REQ_PUSH_FRONT, 32'sh0000_0005);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_POP_REAR, '0);
    send_req(REQ_PUSH_REAR, 32'sh7fff_ffff);
    send_req(REQ_PUSH_REAR, 32'sh8000_0000);
    send_req(REQ_PUSH_REAR, 32'sh0000_0000);
    send_req(REQ_PUSH_REAR, 32'shffff_ffff);
    send_req(REQ_POP_REAR, 32'sh1234_5678);
    send_req(REQ_POP_FRONT, '0);
    wait_idle();
  endtask

  task automatic test_mode_switch_overflow();
    write_mode(MODE_OUTPUT_RESTR);
    send_req(REQ_POP_REAR, '0);
    send_req(REQ_PUSH_FRONT, 32'sha5a5_a5a5);
    send_req(REQ_POP_FRONT, '0);
    for (int n = 0; n < DEPTH - 2; n++) begin
      send_req(n[0] ? REQ_PUSH_REAR : REQ_PUSH_FRONT, $urandom);
    end
    send_req(REQ_PUSH_FRONT, 32'sh5a5a_5a5a);
    send_req(REQ_PUSH_REAR, 32'sh0f0f_0f0f);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    bit                   filling;
    int                   r;
    req_e                 op;
    logic signed [DW-1:0] word;
    filling = 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      write_mode(ph[0] ? MODE_INPUT_RESTR : MODE_OUTPUT_RESTR);
      idling_on = (ph != 2 && ph != 5);
      for (int n = 0; n < 70; n++) begin
        if (count_q == DEPTH && filling && $urandom_range(0, 3) == 0) begin
          filling = 1'b0;
        end else if (count_q == 0 && !filling && $urandom_range(0, 3) == 0) begin
          filling = 1'b1;
        end else if ($urandom_range(0, 29) == 0) begin
          filling = !filling;
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
          op = req_e'($urandom_range(0, 3));
        end else if (filling) begin
          op = (mode_q == MODE_INPUT_RESTR || $urandom_range(0, 1)) ?
               REQ_PUSH_REAR : REQ_PUSH_FRONT;
        end else begin
          op = (mode_q == MODE_OUTPUT_RESTR || $urandom_range(0, 1)) ?
               REQ_POP_FRONT : REQ_POP_REAR;
        end
        r = $urandom_range(0, 9);
        word = (r == 0) ? 32'sh8000_0000 : (r == 1) ? 32'sh7fff_ffff : $urandom;
        send_req(op, word);
      end
      wait_idle();
    end
    idling_on = 1'b1;
  endtask

  initial begin
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_PUSH_REAR;
    req_if.push_value = '0;
    rsp_if.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    front_q           = '0;
    count_q           = '0;
    mode_q            = MODE_INPUT_RESTR;
    mismatch_cnt      = 0;
    idling_on         = 1'b1;
    stall_left        = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_input_restricted();
    test_mode_switch_overflow();
    test_random_traffic();

    wait_idle();
    repeat (4) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
